### sv/pcts_pkg.sv
// Shared types and constants for the priority and credit task scheduler.
`default_nettype none
package pcts_pkg;
   // Number of task entries; the handle and count fields are sized for 16.
   localparam int TASK_SLOTS = 16;
   localparam logic [7:0] CREDIT_CEIL = 8'd255;
   localparam logic [15:0] QUANTUM_RESET = 16'd10;

   typedef enum logic [1:0] {
      ACT_TICK = 2'd0,
      ACT_IRQ = 2'd1,
      ACT_ADD = 2'd2,
      ACT_BLOCK = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_FULL = 2'd1,
      ST_NO_TASK = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN1,
      S_SCAN2,
      S_FINISH,
      S_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic scan1_start;
      logic scan1_step;
      logic scan2_step;
      logic finish;
      logic present;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic need_sched;
      logic empty;
      logic last;
      logic crit_hit;
      logic found;
   } stat_type;
endpackage
`default_nettype wire

### sv/pcts_ctrl.sv
// Controller state machine that sequences one request through the datapath.
`default_nettype none
module pcts_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pcts_pkg::cmd_type      cmd,
   input  wire pcts_pkg::stat_type stat
);
   pcts_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcts_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         pcts_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = pcts_pkg::S_EXEC;
            end
         end
         pcts_pkg::S_EXEC: begin
            if (stat.is_tick && stat.need_sched && !stat.empty) begin
               cmd.scan1_start = 1'b1;
               state_in = pcts_pkg::S_SCAN1;
            end else begin
               cmd.exec = 1'b1;
               state_in = pcts_pkg::S_OUT;
            end
         end
         pcts_pkg::S_SCAN1: begin
            cmd.scan1_step = 1'b1;
            if (stat.crit_hit || stat.last) begin
               if (!stat.crit_hit && stat.found) begin
                  state_in = pcts_pkg::S_SCAN2;
               end else begin
                  state_in = pcts_pkg::S_FINISH;
               end
            end
         end
         pcts_pkg::S_SCAN2: begin
            if (stat.last) begin
               state_in = pcts_pkg::S_FINISH;
            end
            cmd.scan2_step = 1'b1;
         end
         pcts_pkg::S_FINISH: begin
            cmd.finish = 1'b1;
            state_in = pcts_pkg::S_OUT;
         end
         pcts_pkg::S_OUT: begin
            rsp_valid = 1'b1;
            cmd.present = 1'b1;
            if (rsp_ready) begin
               state_in = pcts_pkg::S_IDLE;
            end
         end
         default: state_in = pcts_pkg::S_IDLE;
      endcase
   end

   // The two channels are never both open in the same cycle.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready and valid overlap");
   a_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == pcts_pkg::S_EXEC)
      else $error("accepted request not executed");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
endmodule
`default_nettype wire

### sv/pcts_datapath.sv
// Task tables, ring and scan datapath of the scheduler.
`default_nettype none
module pcts_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pcts_pkg::cmd_type  cmd,
   output pcts_pkg::stat_type      stat,
   input  wire logic               csr_write,
   input  wire logic [15:0]        csr_data,
   input  wire logic [1:0]         req_action,
   input  wire logic [3:0]         req_task_req,
   input  wire logic [7:0]         req_priority_req,
   input  wire logic               req_blocked,
   output logic [1:0]              rsp_status,
   output logic                    rsp_scheduled,
   output logic                    rsp_switched,
   output logic                    rsp_selected_valid,
   output logic [3:0]              rsp_selected_task,
   output logic [31:0]             rsp_selected_runs,
   output logic [4:0]              rsp_pending_count
);
   localparam int IW = $clog2(pcts_pkg::TASK_SLOTS);
   localparam int CW = $clog2(pcts_pkg::TASK_SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(pcts_pkg::TASK_SLOTS);

   logic [7:0]    prio_ff [pcts_pkg::TASK_SLOTS];
   logic [7:0]    credit_ff [pcts_pkg::TASK_SLOTS];
   logic [31:0]   runs_ff [pcts_pkg::TASK_SLOTS];
   logic [IW-1:0] ring_ff [pcts_pkg::TASK_SLOTS];
   logic [pcts_pkg::TASK_SLOTS-1:0] blk_ff, crit_ff;
   logic [IW-1:0] head_ff;
   logic [CW-1:0] total_ff, cnt_ff;
   logic          exec_v_ff;
   logic [IW-1:0] exec_ff;
   logic [15:0]   phase_ff, quantum_ff;
   logic [4:0]    pend_ff;
   logic [1:0]    act_ff;
   logic [3:0]    treq_ff;
   logic [7:0]    preq_ff;
   logic          breq_ff;
   logic [1:0]    status_ff;
   logic          sched_ff, switch_ff, added_ff, got_ff;
   logic [IW-1:0] who_ff, best_ff;
   logic [7:0]    bestc_ff;

   // Scan view of the head entry; a rotated entry goes just past the current tail.
   logic [IW-1:0] cur, tail_idx;
   logic          req_known;
   logic [IW-1:0] req_idx;
   assign cur = ring_ff[head_ff];
   assign tail_idx = IW'(32'(head_ff) + 32'(total_ff));
   assign req_known = CW'(treq_ff) < total_ff;
   assign req_idx = IW'(treq_ff);

   always_comb begin
      stat.is_tick = act_ff == pcts_pkg::ACT_TICK;
      stat.need_sched = phase_ff == 16'd0 || pend_ff != 5'd0
                        || (exec_v_ff && blk_ff[exec_ff]);
      stat.empty = total_ff == '0;
      stat.last = cnt_ff == CW'(32'(total_ff) - 1);
      stat.crit_hit = crit_ff[cur] && !blk_ff[cur];
      stat.found = got_ff || (!blk_ff[cur] && credit_ff[cur] < bestc_ff);
   end

   // Main state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff <= '0;
         crit_ff <= '0;
         head_ff <= '0;
         total_ff <= '0;
         exec_v_ff <= 1'b0;
         exec_ff <= '0;
         phase_ff <= '0;
         pend_ff <= '0;
         quantum_ff <= pcts_pkg::QUANTUM_RESET;
      end else begin
         if (csr_write) quantum_ff <= csr_data;
         if (cmd.load) begin
            act_ff <= req_action;
            treq_ff <= req_task_req;
            preq_ff <= req_priority_req;
            breq_ff <= req_blocked;
         end
         if (cmd.exec || cmd.scan1_start) begin
            status_ff <= pcts_pkg::ST_OK;
            sched_ff <= 1'b0;
            switch_ff <= 1'b0;
            added_ff <= 1'b0;
         end
         // Non-scan actions complete on the exec command.
         if (cmd.exec) begin
            unique case (act_ff)
               pcts_pkg::ACT_TICK: begin
                  if (stat.need_sched) begin
                     // Empty table: nothing found.
                     sched_ff <= 1'b1;
                     switch_ff <= 1'b1;
                     exec_v_ff <= 1'b0;
                     exec_ff <= '0;
                  end
               end
               pcts_pkg::ACT_IRQ: begin
                  if (!req_known) status_ff <= pcts_pkg::ST_NO_TASK;
                  else if (!(exec_v_ff && exec_ff == req_idx) && !crit_ff[req_idx]) begin
                     crit_ff[req_idx] <= 1'b1;
                     pend_ff <= pend_ff + 5'd1;
                  end
               end
               pcts_pkg::ACT_ADD: begin
                  if (total_ff >= SLOTS_C) status_ff <= pcts_pkg::ST_FULL;
                  else begin
                     prio_ff[IW'(total_ff)] <= preq_ff;
                     credit_ff[IW'(total_ff)] <= preq_ff;
                     runs_ff[IW'(total_ff)] <= '0;
                     blk_ff[IW'(total_ff)] <= 1'b0;
                     crit_ff[IW'(total_ff)] <= 1'b0;
                     ring_ff[IW'(32'(head_ff) + 32'(total_ff))] <= IW'(total_ff);
                     total_ff <= total_ff + 1'b1;
                     added_ff <= 1'b1;
                     who_ff <= IW'(total_ff);
                  end
               end
               default: begin
                  if (!req_known) status_ff <= pcts_pkg::ST_NO_TASK;
                  else blk_ff[req_idx] <= breq_ff;
               end
            endcase
         end
         if ((cmd.exec && act_ff == pcts_pkg::ACT_TICK) || cmd.scan1_start) begin
            if (32'(phase_ff) + 32'd1 >= 32'(quantum_ff)) phase_ff <= '0;
            else phase_ff <= phase_ff + 16'd1;
         end
         if (cmd.scan1_start || (cmd.scan1_step && stat.last && !stat.crit_hit)) begin
            cnt_ff <= '0;
         end
         if (cmd.scan1_start) begin
            got_ff <= 1'b0;
            bestc_ff <= pcts_pkg::CREDIT_CEIL;
            sched_ff <= 1'b1;
         end
         // First pass: rotate one entry per cycle, look for critical or least credit.
         if (cmd.scan1_step) begin
            head_ff <= head_ff + 1'b1;
            ring_ff[tail_idx] <= cur;
            if (!stat.last) cnt_ff <= cnt_ff + 1'b1;
            if (stat.crit_hit) begin
               crit_ff[cur] <= 1'b0;
               runs_ff[cur] <= runs_ff[cur] + 32'd1;
               if (pend_ff != 5'd0) pend_ff <= pend_ff - 5'd1;
               who_ff <= cur;
               got_ff <= 1'b1;
               bestc_ff <= '0;
            end else if (!blk_ff[cur] && credit_ff[cur] < bestc_ff) begin
               bestc_ff <= credit_ff[cur];
               best_ff <= cur;
               who_ff <= cur;
               got_ff <= 1'b1;
            end
         end
         // Second pass: charge the winning credit to every other running task.
         if (cmd.scan2_step) begin
            head_ff <= head_ff + 1'b1;
            ring_ff[tail_idx] <= cur;
            cnt_ff <= cnt_ff + 1'b1;
            if (cur != best_ff && !blk_ff[cur]) credit_ff[cur] <= credit_ff[cur] - bestc_ff;
            if (stat.last) begin
               credit_ff[best_ff] <= prio_ff[best_ff];
               runs_ff[best_ff] <= runs_ff[best_ff] + 32'd1;
            end
         end
         if (cmd.finish) begin
            if (!got_ff || !exec_v_ff || who_ff != exec_ff) begin
               switch_ff <= 1'b1;
               exec_v_ff <= got_ff;
               exec_ff <= got_ff ? who_ff : '0;
            end
         end
      end
   end

   // Response fields.
   always_comb begin
      rsp_status = status_ff;
      rsp_scheduled = sched_ff;
      rsp_switched = switch_ff;
      rsp_selected_valid = exec_v_ff;
      rsp_pending_count = pend_ff;
      if (added_ff) begin
         rsp_selected_task = 4'(who_ff);
         rsp_selected_runs = '0;
      end else if (exec_v_ff) begin
         rsp_selected_task = 4'(exec_ff);
         rsp_selected_runs = runs_ff[exec_ff];
      end else begin
         rsp_selected_task = '0;
         rsp_selected_runs = '0;
      end
   end

   a_total: assert property (@(posedge clock) disable iff (reset)
      total_ff <= SLOTS_C) else $error("task count overflow");
   a_pend: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 5'(pcts_pkg::TASK_SLOTS)) else $error("pending overflow");
   a_exec: assert property (@(posedge clock) disable iff (reset)
      exec_v_ff |-> 32'(exec_ff) < 32'(total_ff)) else $error("executing task unknown");
   a_present: assert property (@(posedge clock) disable iff (reset)
      cmd.present |-> !cmd.scan1_step && !cmd.scan2_step) else $error("scan during output");
endmodule
`default_nettype wire

### sv/priority_credit_task_scheduler.sv
// Top level of the priority and credit task scheduler.
// Requests enter on req_valid/req_ready carrying action, task handle, priority
// and blocked state; one response per request leaves on rsp_valid/rsp_ready.
// Actions other than a scheduling tick go through the execute state to the
// response. A scheduling tick walks the task ring one entry per cycle: a first
// pass over up to all N tasks, then, if no critical task is taken and an
// unblocked task is found, a second pass over all N tasks; then a finish step.
// One request is in the block at a time; the next is accepted once the
// response is taken. A stalled response holds unchanged until rsp_ready.
// Synchronous reset empties the table, clears the executing task, the tick
// phase and pending events, and sets quantum_ticks to 10. Write quantum_ticks
// through csr_write/csr_data only while the block is idle; it is not enforced.
`default_nettype none
module priority_credit_task_scheduler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [15:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [3:0]  req_task_req,
   input  wire logic [7:0]  req_priority_req,
   input  wire logic        req_blocked,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_scheduled,
   output logic             rsp_switched,
   output logic             rsp_selected_valid,
   output logic [3:0]       rsp_selected_task,
   output logic [31:0]      rsp_selected_runs,
   output logic [4:0]       rsp_pending_count
);
   pcts_pkg::cmd_type  cmd;
   pcts_pkg::stat_type stat;

   // Controller.
   pcts_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd), .stat(stat)
   );

   // Datapath.
   pcts_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .csr_write(csr_write), .csr_data(csr_data),
      .req_action(req_action), .req_task_req(req_task_req),
      .req_priority_req(req_priority_req), .req_blocked(req_blocked),
      .rsp_status(rsp_status), .rsp_scheduled(rsp_scheduled),
      .rsp_switched(rsp_switched), .rsp_selected_valid(rsp_selected_valid),
      .rsp_selected_task(rsp_selected_task), .rsp_selected_runs(rsp_selected_runs),
      .rsp_pending_count(rsp_pending_count)
   );
endmodule
`default_nettype wire
